// ===== sv/bscu_pkg.sv =====
// Shared types, constants and register indexes of the barometric compensation unit.
package bscu_pkg;

	// Configuration register indexes.
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_T1_T2 = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_T3_P1 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_P2_P3 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_P4_P5 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_P6_P7 = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_P8_P9 = 3'd5;

	// Compensation constants.
	localparam int unsigned OffsetFine = 128000;
	localparam int unsigned PressBase  = 1048576;
	localparam int unsigned PressScale = 3125;
	localparam int unsigned ShiftOne   = 47;
	localparam int unsigned ShiftP4    = 35;
	localparam int unsigned ShiftP1    = 33;
	localparam int unsigned NumShift   = 31;

	// Divider geometry: the divisor is the pressure denominator after its shift.
	localparam int unsigned DivBits = 64;
	localparam int unsigned DenW    = 64 - ShiftP1;

	// Unpacked calibration words.
	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	// Values that ride alongside the division.
	typedef struct packed {
		logic [31:0] temp;
		logic        invalid;
		logic        qneg;
	} side_t;

	// One finished result.
	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] pressure;
		logic        invalid;
	} res_t;

endpackage

// ===== sv/bscu_front.sv =====
// Front pipeline: temperature, fine temperature and the operands of the pressure division.
module bscu_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [19:0]                  raw_t,
	input  logic [19:0]                  raw_p,
	input  bscu_pkg::cal_t               cal,
	output logic                         vld,
	output logic [63:0]                  num_mag,
	output logic [bscu_pkg::DenW-1:0]    den_mag,
	output bscu_pkg::side_t              side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// Stage 1: first temperature products.
	logic signed [17:0] ta;
	logic signed [16:0] td;
	logic signed [33:0] pa, pd;
	logic signed [22:0] x1_s1;
	logic signed [21:0] dd_s1;
	logic [20:0] pb_s1;

	assign ta = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
	assign td = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, cal.t1});
	assign pa = ta * cal.t2;
	assign pd = td * td;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= pa[33:11];
			dd_s1 <= pd[33:12];
			pb_s1 <= 21'(bscu_pkg::PressBase) - {1'b0, raw_p};
		end
	end

	// Stage 2: fine temperature.
	logic signed [37:0] py;
	logic signed [23:0] yy;
	logic signed [24:0] fine_c, fine_s2;
	logic [20:0] pb_s2;

	assign py = dd_s1 * cal.t3;
	assign yy = py[37:14];
	assign fine_c = x1_s1 + yy;

	always_ff @(posedge clk) begin
		if (en) begin
			fine_s2 <= fine_c;
			pb_s2 <= pb_s1;
		end
	end

	// Stage 3: temperature result and pressure offset.
	logic signed [27:0] t5;
	logic signed [19:0] tq;
	logic signed [25:0] off_c, off_s3;
	logic signed [31:0] temp_s3;
	logic [20:0] pb_s3;

	assign t5 = fine_s2 * 28'sd5 + 28'sd128;
	assign tq = t5[27:8];
	assign off_c = fine_s2 - $signed(26'(bscu_pkg::OffsetFine));

	always_ff @(posedge clk) begin
		if (en) begin
			off_s3 <= off_c;
			temp_s3 <= 32'(tq);
			pb_s3 <= pb_s2;
		end
	end

	// Stage 4: products of the offset.
	logic signed [51:0] oo_c, oo_s4;
	logic signed [41:0] o5_c, o2_c, o5_s4, o2_s4;
	logic [31:0] temp_s4;
	logic [20:0] pb_s4;

	assign oo_c = off_s3 * off_s3;
	assign o5_c = off_s3 * cal.p5;
	assign o2_c = off_s3 * cal.p2;

	always_ff @(posedge clk) begin
		if (en) begin
			oo_s4 <= oo_c;
			o5_s4 <= o5_c;
			o2_s4 <= o2_c;
			temp_s4 <= temp_s3;
			pb_s4 <= pb_s3;
		end
	end

	// Stage 5: square terms, wrapped to 64 bits.
	logic signed [67:0] m6, m3;
	logic signed [63:0] m3w;
	logic signed [63:0] a6_s5, a3_s5;
	logic signed [41:0] o5_s5, o2_s5;
	logic [31:0] temp_s5;
	logic [20:0] pb_s5;

	assign m6 = oo_s4 * cal.p6;
	assign m3 = oo_s4 * cal.p3;
	assign m3w = m3[63:0];

	always_ff @(posedge clk) begin
		if (en) begin
			a6_s5 <= m6[63:0];
			a3_s5 <= m3w >>> 8;
			o5_s5 <= o5_s4;
			o2_s5 <= o2_s4;
			temp_s5 <= temp_s4;
			pb_s5 <= pb_s4;
		end
	end

	// Stage 6: sums of the second and first pressure variables.
	logic signed [63:0] e5, e2, e4, v2_c, x_c, v2_s6, x_s6;
	logic [31:0] temp_s6;
	logic [20:0] pb_s6;

	assign e5 = 64'(o5_s5);
	assign e2 = 64'(o2_s5);
	assign e4 = 64'(cal.p4);
	assign v2_c = a6_s5 + (e5 <<< 17) + (e4 <<< bscu_pkg::ShiftP4);
	assign x_c = a3_s5 + (e2 <<< 12) + (64'sd1 <<< bscu_pkg::ShiftOne);

	always_ff @(posedge clk) begin
		if (en) begin
			v2_s6 <= v2_c;
			x_s6 <= x_c;
			temp_s6 <= temp_s5;
			pb_s6 <= pb_s5;
		end
	end

	// Stage 7: numerator base and halves of the denominator product.
	logic [63:0] n0_c, n0_s7;
	logic [47:0] dlo_c, dlo_s7;
	logic [31:0] dhi_c, dhi_s7;
	logic [31:0] temp_s7;

	assign n0_c = ({43'd0, pb_s6} << bscu_pkg::NumShift) - v2_s6;
	assign dlo_c = x_s6[31:0] * cal.p1;
	assign dhi_c = x_s6[63:32] * {16'd0, cal.p1};

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s7 <= n0_c;
			dlo_s7 <= dlo_c;
			dhi_s7 <= dhi_c;
			temp_s7 <= temp_s6;
		end
	end

	// Stage 8: denominator and scaled numerator.
	logic [63:0] prod_c, num_c, num_s8;
	logic signed [bscu_pkg::DenW-1:0] den_c, den_s8;
	logic [31:0] temp_s8;
	logic inv_s8;

	assign prod_c = {dhi_s7, 32'd0} + {16'd0, dlo_s7};
	assign den_c = prod_c[63:bscu_pkg::ShiftP1];
	assign num_c = n0_s7 * 64'(bscu_pkg::PressScale);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s8 <= num_c;
			den_s8 <= den_c;
			inv_s8 <= (den_c == '0);
			temp_s8 <= temp_s7;
		end
	end

	// Stage 9: magnitudes and quotient sign.
	logic num_neg, den_neg;
	logic [63:0] ua_c;
	logic [bscu_pkg::DenW-1:0] ub_c;

	assign num_neg = num_s8[63];
	assign den_neg = den_s8[bscu_pkg::DenW-1];
	assign ua_c = num_neg ? (64'd0 - num_s8) : num_s8;
	assign ub_c = den_neg ? ('0 - den_s8) : den_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			num_mag <= ua_c;
			den_mag <= ub_c;
			side.temp <= temp_s8;
			side.invalid <= inv_s8;
			side.qneg <= num_neg ^ den_neg;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign vld = v_s9;

endmodule

// ===== sv/bscu_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
module bscu_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [63:0]                  dvd,
	input  logic [bscu_pkg::DenW-1:0]    dsr,
	input  bscu_pkg::side_t              side_in,
	output logic                         out_vld,
	output logic [63:0]                  quo,
	output bscu_pkg::side_t              side_out
);

	localparam int unsigned N = bscu_pkg::DivBits;
	localparam int unsigned W = bscu_pkg::DenW;

	logic            vld_s  [N];
	logic [W-1:0]    rem_s  [N];
	logic [63:0]     dvd_s  [N];
	logic [W-1:0]    dsr_s  [N];
	bscu_pkg::side_t side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_bit
		logic            vi;
		logic [W-1:0]    ri, di;
		logic [63:0]     qi;
		bscu_pkg::side_t si;
		logic [W:0]      trial, diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign vi = in_vld;
			assign ri = '0;
			assign qi = dvd;
			assign di = dsr;
			assign si = side_in;
		end else begin : g_next
			assign vi = vld_s[k-1];
			assign ri = rem_s[k-1];
			assign qi = dvd_s[k-1];
			assign di = dsr_s[k-1];
			assign si = side_s[k-1];
		end

		// The dividend shifts out at the top while quotient bits shift in at the bottom.
		assign trial = {ri, qi[63]};
		assign diff = trial - {1'b0, di};
		assign ge = (trial >= {1'b0, di});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[W-1:0] : trial[W-1:0];
				dvd_s[k] <= {qi[62:0], ge};
				dsr_s[k] <= di;
				side_s[k] <= si;
			end
		end
	end

	assign out_vld = vld_s[N-1];
	assign quo = dvd_s[N-1];
	assign side_out = side_s[N-1];

endmodule

// ===== sv/bscu_back.sv =====
// Back pipeline: signed quotient, second-order pressure corrections and final result.
module bscu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [63:0]       quo,
	input  bscu_pkg::side_t   side_in,
	input  bscu_pkg::cal_t    cal,
	output logic              vld,
	output bscu_pkg::res_t    res
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [31:0] p8x, p9x;
	assign p8x = 32'(cal.p8);
	assign p9x = 32'(cal.p9);

	// Stage 1: apply the quotient sign.
	logic signed [63:0] p_s1;
	bscu_pkg::side_t sd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= side_in.qneg ? (64'sd0 - $signed(quo)) : $signed(quo);
			sd_s1 <= side_in;
		end
	end

	// Stage 2: partial products of the square and of the P8 term.
	logic signed [63:0] s_c;
	logic [63:0] mll_c, mll_s2;
	logic [31:0] mlh_c, mlh_s2, ph8_c, ph8_s2;
	logic signed [48:0] pl8_c, pl8_s2;
	logic signed [63:0] p_s2;
	bscu_pkg::side_t sd_s2;

	assign s_c = p_s1 >>> 13;
	assign mll_c = s_c[31:0] * s_c[31:0];
	assign mlh_c = s_c[31:0] * s_c[63:32];
	assign pl8_c = $signed({1'b0, p_s1[31:0]}) * cal.p8;
	assign ph8_c = p_s1[63:32] * p8x;

	always_ff @(posedge clk) begin
		if (en) begin
			mll_s2 <= mll_c;
			mlh_s2 <= mlh_c;
			pl8_s2 <= pl8_c;
			ph8_s2 <= ph8_c;
			p_s2 <= p_s1;
			sd_s2 <= sd_s1;
		end
	end

	// Stage 3: square wrapped to 64 bits and the P8 correction.
	logic signed [63:0] e8, q8_c;
	logic [63:0] ss_c, ss_s3;
	logic signed [63:0] v2_s3, p_s3;
	bscu_pkg::side_t sd_s3;

	assign ss_c = mll_s2 + ({32'd0, mlh_s2} << 33);
	assign e8 = 64'(pl8_s2);
	assign q8_c = e8 + $signed({ph8_s2, 32'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s3 <= ss_c;
			v2_s3 <= q8_c >>> 19;
			p_s3 <= p_s2;
			sd_s3 <= sd_s2;
		end
	end

	// Stage 4: partial products of the P9 term.
	logic signed [48:0] pl9_c, pl9_s4;
	logic [31:0] ph9_c, ph9_s4;
	logic signed [63:0] v2_s4, p_s4;
	bscu_pkg::side_t sd_s4;

	assign pl9_c = $signed({1'b0, ss_s3[31:0]}) * cal.p9;
	assign ph9_c = ss_s3[63:32] * p9x;

	always_ff @(posedge clk) begin
		if (en) begin
			pl9_s4 <= pl9_c;
			ph9_s4 <= ph9_c;
			v2_s4 <= v2_s3;
			p_s4 <= p_s3;
			sd_s4 <= sd_s3;
		end
	end

	// Stage 5: sum, scale and P7 offset; a zero divisor forces the pressure to zero.
	logic signed [63:0] e9, t9_c, v1_c, sum_c, e7, pr_c;

	assign e9 = 64'(pl9_s4);
	assign t9_c = e9 + $signed({ph9_s4, 32'd0});
	assign v1_c = t9_c >>> 25;
	assign sum_c = p_s4 + v1_c + v2_s4;
	assign e7 = 64'(cal.p7);
	assign pr_c = (sum_c >>> 8) + (e7 <<< 4);

	always_ff @(posedge clk) begin
		if (en) begin
			res.temp <= sd_s4.temp;
			res.invalid <= sd_s4.invalid;
			res.pressure <= sd_s4.invalid ? 32'd0 : pr_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign vld = v_s5;

endmodule

// ===== sv/baro_sensor_compensation_unit.sv =====
// Top level of the barometric compensation unit: configuration, pipeline and output buffer.
//
// This unit takes one pair of raw 20-bit temperature and pressure readings per beat and
// returns the temperature in hundredths of a degree and the pressure in unsigned Q24.8
// pascals, using the 64-bit integer compensation with one signed division. A new reading
// pair is accepted on every clock while the two-entry output buffer has room; a result
// passes through nine front stages, the 64-stage divider (one quotient bit per stage),
// five back stages and the buffer. When the pressure divisor is zero the pressure comes
// out as zero and pressure_invalid is set; the temperature is still valid. The
// calibration registers are written through cfg_we, cfg_index and cfg_wdata and must
// only be changed while no reading is in flight; writes to an index beyond the six
// registers are dropped.
module baro_sensor_compensation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] temperature_centi,
	output logic [31:0] pressure_q24_8,
	output logic        pressure_invalid
);

	// Calibration registers.
	logic [31:0] cal_t1_t2_q, cal_t3_p1_q, cal_p2_p3_q, cal_p4_p5_q, cal_p6_p7_q, cal_p8_p9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_t2_q <= '0;
			cal_t3_p1_q <= '0;
			cal_p2_p3_q <= '0;
			cal_p4_p5_q <= '0;
			cal_p6_p7_q <= '0;
			cal_p8_p9_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bscu_pkg::REG_T1_T2: cal_t1_t2_q <= cfg_wdata;
				bscu_pkg::REG_T3_P1: cal_t3_p1_q <= cfg_wdata;
				bscu_pkg::REG_P2_P3: cal_p2_p3_q <= cfg_wdata;
				bscu_pkg::REG_P4_P5: cal_p4_p5_q <= cfg_wdata;
				bscu_pkg::REG_P6_P7: cal_p6_p7_q <= cfg_wdata;
				bscu_pkg::REG_P8_P9: cal_p8_p9_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	bscu_pkg::cal_t cal;

	assign cal.t1 = cal_t1_t2_q[31:16];
	assign cal.t2 = cal_t1_t2_q[15:0];
	assign cal.t3 = cal_t3_p1_q[31:16];
	assign cal.p1 = cal_t3_p1_q[15:0];
	assign cal.p2 = cal_p2_p3_q[31:16];
	assign cal.p3 = cal_p2_p3_q[15:0];
	assign cal.p4 = cal_p4_p5_q[31:16];
	assign cal.p5 = cal_p4_p5_q[15:0];
	assign cal.p6 = cal_p6_p7_q[31:16];
	assign cal.p7 = cal_p6_p7_q[15:0];
	assign cal.p8 = cal_p8_p9_q[31:16];
	assign cal.p9 = cal_p8_p9_q[15:0];

	// The whole pipeline moves together. It only stops when the output buffer is full,
	// so the stall decision comes from a register and never from out_ready.
	logic [1:0] cnt_q;
	logic       en;

	assign en = (cnt_q != 2'd2);
	assign in_ready = en;

	logic                           fr_vld;
	logic [63:0]                    fr_num;
	logic [bscu_pkg::DenW-1:0]      fr_den;
	bscu_pkg::side_t                fr_side;

	bscu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.raw_t   (raw_temperature),
		.raw_p   (raw_pressure),
		.cal     (cal),
		.vld     (fr_vld),
		.num_mag (fr_num),
		.den_mag (fr_den),
		.side    (fr_side)
	);

	logic            dv_vld;
	logic [63:0]     dv_quo;
	bscu_pkg::side_t dv_side;

	bscu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fr_vld),
		.dvd      (fr_num),
		.dsr      (fr_den),
		.side_in  (fr_side),
		.out_vld  (dv_vld),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	logic           bk_vld;
	bscu_pkg::res_t bk_res;

	bscu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (dv_vld),
		.quo     (dv_quo),
		.side_in (dv_side),
		.cal     (cal),
		.vld     (bk_vld),
		.res     (bk_res)
	);

	// Two-entry output buffer. With one entry held, the pipeline may still push one more
	// beat, after which it stalls until a beat is taken.
	bscu_pkg::res_t fifo_q [2];
	logic           wr_q, rd_q;
	logic           push, pop;

	assign push = bk_vld && en;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= bk_res;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign temperature_centi = fifo_q[rd_q].temp;
	assign pressure_q24_8 = fifo_q[rd_q].pressure;
	assign pressure_invalid = fifo_q[rd_q].invalid;

	// The buffer never holds more than two beats.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	// The count follows pushes and pops exactly.
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cnt_q == $past(cnt_q) + {1'b0, $past(push)} - {1'b0, $past(pop)})
		else $error("output buffer count lost track of beats");

	// A flagged result always carries a zero pressure.
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pressure_invalid) |-> pressure_q24_8 == 32'd0)
		else $error("invalid pressure result is not zero");

	// A full buffer does not drop to empty unless a beat was popped.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |=> cnt_q != 2'd0 || $past(pop))
		else $error("output buffer drained without a pop");

endmodule
